// File: design/assert_macros.svh
// Assertion helpers for the verification files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define MMR_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Concurrent assertion on the house clock and reset names.
`define MMR_ASSERT(lbl, prop) `MMR_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// File: design/mmr_pkg.sv
package mmr_pkg;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 3;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned CRC_W   = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Protocol constants
  localparam logic [BYTE_W-1:0] FC_READ_INPUT = 8'h04;
  localparam logic [BYTE_W-1:0] RESP_BYTE_CNT = 8'h14;
  localparam logic [CRC_W-1:0]  CRC_INIT      = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY      = 16'hA001;

  // Positions of the response bytes
  localparam logic [IDX_W-1:0] B_ADDR    = 5'd0;
  localparam logic [IDX_W-1:0] B_FUNC    = 5'd1;
  localparam logic [IDX_W-1:0] B_COUNT   = 5'd2;
  localparam logic [IDX_W-1:0] B_VOLT_H  = 5'd3;
  localparam logic [IDX_W-1:0] B_VOLT_L  = 5'd4;
  localparam logic [IDX_W-1:0] B_CUR_0   = 5'd5;
  localparam logic [IDX_W-1:0] B_CUR_1   = 5'd6;
  localparam logic [IDX_W-1:0] B_CUR_2   = 5'd7;
  localparam logic [IDX_W-1:0] B_CUR_3   = 5'd8;
  localparam logic [IDX_W-1:0] B_PWR_0   = 5'd9;
  localparam logic [IDX_W-1:0] B_PWR_1   = 5'd10;
  localparam logic [IDX_W-1:0] B_PWR_2   = 5'd11;
  localparam logic [IDX_W-1:0] B_PWR_3   = 5'd12;
  localparam logic [IDX_W-1:0] B_NRG_0   = 5'd13;
  localparam logic [IDX_W-1:0] B_NRG_1   = 5'd14;
  localparam logic [IDX_W-1:0] B_NRG_2   = 5'd15;
  localparam logic [IDX_W-1:0] B_NRG_3   = 5'd16;
  localparam logic [IDX_W-1:0] B_FREQ_H  = 5'd17;
  localparam logic [IDX_W-1:0] B_FREQ_L  = 5'd18;
  localparam logic [IDX_W-1:0] B_PF_H    = 5'd19;
  localparam logic [IDX_W-1:0] B_PF_L    = 5'd20;
  localparam logic [IDX_W-1:0] B_ALARM_H = 5'd21;
  localparam logic [IDX_W-1:0] B_ALARM_L = 5'd22;
  localparam logic [IDX_W-1:0] B_CRC_L   = 5'd23;
  localparam logic [IDX_W-1:0] B_CRC_H   = 5'd24;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOLTAGE = 3'd0,
    CFG_CURRENT = 3'd1,
    CFG_POWER   = 3'd2,
    CFG_ENERGY  = 3'd3,
    CFG_FREQ    = 3'd4,
    CFG_PF      = 3'd5
  } cfg_idx_e;

  // Measurement registers
  typedef struct packed {
    logic [15:0] voltage_tenths;
    logic [31:0] current_milliamps;
    logic [31:0] power_tenths;
    logic [31:0] energy_wh;
    logic [15:0] frequency_tenths;
    logic [6:0]  power_factor_hundredths;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    voltage_tenths:          16'd2200,
    current_milliamps:       32'd30000,
    power_tenths:            32'd34000,
    energy_wh:               32'd14400,
    frequency_tenths:        16'd600,
    power_factor_hundredths: 7'd98
  };

  // One queued read request
  typedef struct packed {
    logic [BYTE_W-1:0] slave_address;
  } req_t;

  // Modbus CRC-16, one byte folded in, LSB first
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                 input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: design/mmr_if.sv
// Request byte channel
interface mmr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Response byte channel
interface mmr_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       frame_end;

  modport source (output valid, output tx_byte, output frame_end, input ready);
  modport sink   (input valid, input tx_byte, input frame_end, output ready);
endinterface

// File: design/mmr_front.sv
module mmr_front #(
  parameter int unsigned REQUEST_LENGTH = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mmr_rx_if.sink        rx,
  input  logic          q_full_i,
  output logic          q_push_o,
  output mmr_pkg::req_t q_req_o
);
  import mmr_pkg::*;

  localparam logic [POS_W-1:0] LastPos = POS_W'(REQUEST_LENGTH - 1);

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [BYTE_W-1:0] addr_q, addr_d;
  logic [BYTE_W-1:0] fc_q, fc_d;
  logic              beat;
  logic              last;

  // Stall only when a finished request would find the queue full
  assign rx.ready = !(q_full_i && last);
  assign beat     = rx.valid && rx.ready;
  assign last     = (pos_q == LastPos);

  // Capture header bytes and count frame position
  always_comb begin
    pos_d  = pos_q;
    addr_d = addr_q;
    fc_d   = fc_q;
    if (beat) begin
      if (pos_q == POS_W'(0)) begin
        addr_d = rx.rx_byte;
      end
      if (pos_q == POS_W'(1)) begin
        fc_d = rx.rx_byte;
      end
      pos_d = last ? POS_W'(0) : pos_q + POS_W'(1);
    end
  end

  // Classify: push a read request on the last byte of a function 4 frame
  assign q_push_o              = beat && last && (fc_d == FC_READ_INPUT);
  assign q_req_o.slave_address = addr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      addr_q <= '0;
      fc_q   <= '0;
    end else begin
      pos_q  <= pos_d;
      addr_q <= addr_d;
      fc_q   <= fc_d;
    end
  end

endmodule

// File: design/mmr_queue.sv
module mmr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mmr_pkg::req_t push_req_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          pop_valid_o,
  output mmr_pkg::req_t pop_req_o
);
  import mmr_pkg::*;

  // Two-entry request queue
  req_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o      = (cnt_q == 2'd2);
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop_req_o   = entry_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_req_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// File: design/mmr_back.sv
module mmr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mmr_pkg::cfg_t cfg_i,
  input  logic          req_valid_i,
  input  mmr_pkg::req_t req_i,
  output logic          req_pop_o,
  mmr_tx_if.source      tx
);
  import mmr_pkg::*;

  logic              busy_q;
  logic [IDX_W-1:0]  idx_q;
  logic [BYTE_W-1:0] addr_q;
  logic [CRC_W-1:0]  crc_q;
  logic              out_vld_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_end_q;
  logic              adv;
  logic [BYTE_W-1:0] cur_byte;

  // Start the next response when idle
  assign req_pop_o = !busy_q && req_valid_i;
  // Move one byte into the output register when it is free
  assign adv       = busy_q && (!out_vld_q || tx.ready);

  // Select the response byte at the current position
  always_comb begin
    unique case (idx_q)
      B_ADDR:    cur_byte = addr_q;
      B_FUNC:    cur_byte = FC_READ_INPUT;
      B_COUNT:   cur_byte = RESP_BYTE_CNT;
      B_VOLT_H:  cur_byte = cfg_i.voltage_tenths[15:8];
      B_VOLT_L:  cur_byte = cfg_i.voltage_tenths[7:0];
      B_CUR_0:   cur_byte = cfg_i.current_milliamps[15:8];
      B_CUR_1:   cur_byte = cfg_i.current_milliamps[7:0];
      B_CUR_2:   cur_byte = cfg_i.current_milliamps[31:24];
      B_CUR_3:   cur_byte = cfg_i.current_milliamps[23:16];
      B_PWR_0:   cur_byte = cfg_i.power_tenths[15:8];
      B_PWR_1:   cur_byte = cfg_i.power_tenths[7:0];
      B_PWR_2:   cur_byte = cfg_i.power_tenths[31:24];
      B_PWR_3:   cur_byte = cfg_i.power_tenths[23:16];
      B_NRG_0:   cur_byte = cfg_i.energy_wh[15:8];
      B_NRG_1:   cur_byte = cfg_i.energy_wh[7:0];
      B_NRG_2:   cur_byte = cfg_i.energy_wh[31:24];
      B_NRG_3:   cur_byte = cfg_i.energy_wh[23:16];
      B_FREQ_H:  cur_byte = cfg_i.frequency_tenths[15:8];
      B_FREQ_L:  cur_byte = cfg_i.frequency_tenths[7:0];
      B_PF_H:    cur_byte = 8'h00;
      B_PF_L:    cur_byte = {1'b0, cfg_i.power_factor_hundredths};
      B_ALARM_H: cur_byte = 8'h00;
      B_ALARM_L: cur_byte = 8'h00;
      B_CRC_L:   cur_byte = crc_q[7:0];
      B_CRC_H:   cur_byte = crc_q[15:8];
      default:   cur_byte = 8'h00;
    endcase
  end

  // Sequence the response byte positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (req_pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= B_ADDR;
    end else if (adv) begin
      idx_q <= idx_q + IDX_W'(1);
      if (idx_q == B_CRC_H) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Payload of the running response
  always_ff @(posedge clk_i) begin
    if (req_pop_o) begin
      addr_q <= req_i.slave_address;
      crc_q  <= CRC_INIT;
    end else if (adv && (idx_q < B_CRC_L)) begin
      crc_q <= crc_byte(crc_q, cur_byte);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (tx.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q <= cur_byte;
      out_end_q  <= (idx_q == B_CRC_H);
    end
  end

  assign tx.valid     = out_vld_q;
  assign tx.tx_byte   = out_byte_q;
  assign tx.frame_end = out_end_q;

endmodule

// File: design/modbus_meter_read_responder.sv
// The last byte of a read request goes into the two-entry request queue; when idle, the
// serializer takes it and sends the response bytes through its output register. Request
// bytes come in one per cycle, held back only at a frame end while the queue is full;
// responses go out one byte per cycle while the receiver is ready, 25 bytes per frame.
// Reset: asynchronous, active low; clears the frame position, header bytes, queue and
// output, and loads the measurement registers with their default values.
module modbus_meter_read_responder #(
  parameter int unsigned REQUEST_LENGTH = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mmr_rx_if.sink                          rx,
  mmr_tx_if.source                        tx,
  input  logic                            cfg_we_i,
  input  logic [mmr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mmr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import mmr_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic q_full, q_push, q_pop, q_valid;
  req_t push_req, pop_req;

  // Decode register writes; writes beyond the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VOLTAGE: cfg_d.voltage_tenths          = cfg_data_i[15:0];
        CFG_CURRENT: cfg_d.current_milliamps       = cfg_data_i;
        CFG_POWER:   cfg_d.power_tenths            = cfg_data_i;
        CFG_ENERGY:  cfg_d.energy_wh               = cfg_data_i;
        CFG_FREQ:    cfg_d.frequency_tenths        = cfg_data_i[15:0];
        CFG_PF:      cfg_d.power_factor_hundredths = cfg_data_i[6:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mmr_front #(
    .REQUEST_LENGTH(REQUEST_LENGTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx       (rx),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_req_o  (push_req)
  );

  mmr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_req_i  (push_req),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_valid_o (q_valid),
    .pop_req_o   (pop_req)
  );

  mmr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_valid_i (q_valid),
    .req_i       (pop_req),
    .req_pop_o   (q_pop),
    .tx          (tx)
  );

endmodule

// File: design/mmr_checker.sv
`include "assert_macros.svh"

module mmr_checker #(
  parameter int unsigned REQUEST_LENGTH = 8
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rx_valid_i,
  input logic       rx_ready_i,
  input logic [7:0] rx_byte_i,
  input logic       tx_valid_i,
  input logic       tx_ready_i,
  input logic [7:0] tx_byte_i,
  input logic       frame_end_i
);
  import mmr_pkg::*;

  localparam logic [POS_W-1:0] LastPos = POS_W'(REQUEST_LENGTH - 1);

  logic [POS_W-1:0]  pos_q;
  logic [BYTE_W-1:0] fc_q;
  logic [BYTE_W-1:0] fc_now;
  logic [IDX_W-1:0]  cnt_q;
  logic [2:0]        pend_q;
  logic              in_beat, out_beat, req_done, resp_done;

  assign in_beat   = rx_valid_i && rx_ready_i;
  assign out_beat  = tx_valid_i && tx_ready_i;
  assign fc_now    = (pos_q == POS_W'(1)) ? rx_byte_i : fc_q;
  assign req_done  = in_beat && (pos_q == LastPos) && (fc_now == FC_READ_INPUT);
  assign resp_done = out_beat && frame_end_i;

  // Track request framing, response byte count and open responses
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fc_q   <= '0;
      cnt_q  <= '0;
      pend_q <= '0;
    end else begin
      if (in_beat) begin
        fc_q  <= fc_now;
        pos_q <= (pos_q == LastPos) ? POS_W'(0) : pos_q + POS_W'(1);
      end
      if (out_beat) begin
        cnt_q <= frame_end_i ? IDX_W'(0) : cnt_q + IDX_W'(1);
      end
      if (req_done && !resp_done) begin
        pend_q <= pend_q + 3'd1;
      end else if (resp_done && !req_done) begin
        pend_q <= pend_q - 3'd1;
      end
    end
  end

  // Hold a stalled response beat
  `MMR_ASSERT(a_tx_hold, tx_valid_i && !tx_ready_i |=> tx_valid_i && $stable(tx_byte_i) && $stable(frame_end_i))
  // Mark the end exactly on the last byte of a response
  `MMR_ASSERT(a_frame_len, out_beat |-> (frame_end_i == (cnt_q == B_CRC_H)))
  // Send the function code and byte count in their places
  `MMR_ASSERT(a_header, out_beat && (cnt_q == B_FUNC || cnt_q == B_COUNT) |-> (tx_byte_i == ((cnt_q == B_FUNC) ? FC_READ_INPUT : RESP_BYTE_CNT)))
  // Start a response only for a completed read request
  `MMR_ASSERT(a_no_orphan, out_beat && (cnt_q == B_ADDR) |-> (pend_q != 3'd0))

endmodule

bind modbus_meter_read_responder mmr_checker #(
  .REQUEST_LENGTH(REQUEST_LENGTH)
) u_mmr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rx_valid_i  (rx.valid),
  .rx_ready_i  (rx.ready),
  .rx_byte_i   (rx.rx_byte),
  .tx_valid_i  (tx.valid),
  .tx_ready_i  (tx.ready),
  .tx_byte_i   (tx.tx_byte),
  .frame_end_i (tx.frame_end)
);
